// File: rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the sorted child table: operation and
// status codes, field widths, and the record a cell hands to its neighbor.
// ----------------------------------------------------------------------------
package sct_pkg;

  // default sizing of the table
  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned RefBitsDef    = 20;

  // fixed widths of the request and response fields
  localparam int unsigned KeyW        = 8;
  localparam int unsigned RefFieldW   = 20;
  localparam int unsigned EntryCountW = 6;

  // cells per first-level select group
  localparam int unsigned GroupSize = 8;

  // operation code of a request
  typedef enum logic {
    FuncInsert = 1'b0,
    FuncLookup = 1'b1
  } sct_func_e;

  // status code of a response
  typedef enum logic {
    StatusOk   = 1'b0,
    StatusFull = 1'b1
  } sct_status_e;

  // what a cell shows to the cell above it
  typedef struct packed {
    logic            gt;    // occupied and key greater than request key
    logic            term;
    logic [KeyW-1:0] key;
  } sct_nbr_t;

endpackage

// File: rtl/sct_cell.sv
// ----------------------------------------------------------------------------
// sct_cell
// One slot of the sorted table. On an insert the slot either keeps its
// entry, takes the entry of the slot below, or takes the new entry. On a
// lookup it flags a non-terminal key match.
// ----------------------------------------------------------------------------
module sct_cell #(
  parameter int unsigned RefBits = sct_pkg::RefBitsDef
) (
  input  logic                       clk_i,
  input  logic                       ins_i,
  input  logic [sct_pkg::KeyW-1:0]   key_i,
  input  logic [RefBits-1:0]         ref_i,
  input  logic                       term_i,
  input  logic                       occ_i,
  input  sct_pkg::sct_nbr_t          prev_i,
  input  logic [RefBits-1:0]         prev_ref_i,
  output sct_pkg::sct_nbr_t          nbr_o,
  output logic [RefBits-1:0]         ref_o,
  output logic                       match_o
);

  logic [sct_pkg::KeyW-1:0] key_q, key_d;
  logic [RefBits-1:0]       ref_q, ref_d;
  logic                     term_q, term_d;
  logic                     gt_own;

  // compare against the request key
  assign gt_own  = occ_i && (key_q > key_i);
  assign match_o = occ_i && (key_q == key_i) && !term_q;

  assign nbr_o.gt   = gt_own;
  assign nbr_o.term = term_q;
  assign nbr_o.key  = key_q;
  assign ref_o      = ref_q;

  // shift up, take the new entry, or hold
  always_comb begin
    key_d  = key_q;
    ref_d  = ref_q;
    term_d = term_q;
    if (ins_i) begin
      if (prev_i.gt) begin
        key_d  = prev_i.key;
        ref_d  = prev_ref_i;
        term_d = prev_i.term;
      end else if (gt_own || !occ_i) begin
        key_d  = key_i;
        ref_d  = ref_i;
        term_d = term_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    ref_q  <= ref_d;
    term_q <= term_d;
  end

endmodule

// File: rtl/sct_group.sv
// ----------------------------------------------------------------------------
// sct_group
// First level of the lookup select: picks the lowest matching cell of a
// group of cells and registers its hit flag and reference.
// ----------------------------------------------------------------------------
module sct_group #(
  parameter int unsigned RefBits = sct_pkg::RefBitsDef
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [sct_pkg::GroupSize-1:0] match_i,
  input  logic [RefBits-1:0]            ref_i [sct_pkg::GroupSize],
  output logic                          hit_o,
  output logic [RefBits-1:0]            ref_o
);

  logic               hit_q, hit_d;
  logic [RefBits-1:0] ref_q, ref_d;

  // lowest-placed match wins
  always_comb begin
    hit_d = 1'b0;
    ref_d = '0;
    for (int i = sct_pkg::GroupSize - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        hit_d = 1'b1;
        ref_d = ref_i[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hit_q <= hit_d;
      ref_q <= ref_d;
    end
  end

  assign hit_o = hit_q;
  assign ref_o = ref_q;

endmodule

// File: rtl/sorted_child_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_child_table_unit
// Table of child entries kept sorted by key in a row of cells. An insert
// shifts every greater entry up one cell in parallel; a lookup
// reports the lowest non-terminal entry whose key matches.
//
//   channel   direction   handshake               payload
//   request   in          in_valid_i/in_stall_o   func, key, ref_in, terminal_in
//   response  out         out_valid_o/out_stall_i found, ref_out, status,
//                                                 entry_count
//
// One request per cycle while in_stall_o is low; an accepted request loads
// a select register stage over groups of cells, and that stage then loads
// the output register that shows the response. The registered path is set
// by the two-level match select.
// Reset empties the table at once; no sweep is needed.
// A stalled response holds the output register, the select stage can still
// fill behind it, and only then is the request side stalled.
// ----------------------------------------------------------------------------
module sorted_child_table_unit #(
  parameter int unsigned TableDepth = sct_pkg::TableDepthDef,
  parameter int unsigned RefBits    = sct_pkg::RefBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [sct_pkg::KeyW-1:0]          key_i,
  input  logic [sct_pkg::RefFieldW-1:0]     ref_in_i,
  input  logic                              terminal_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [sct_pkg::RefFieldW-1:0]     ref_out_o,
  output logic                              status_o,
  output logic [sct_pkg::EntryCountW-1:0]   entry_count_o
);

  localparam int unsigned CntW   = $clog2(TableDepth + 1);
  localparam int unsigned NumGrp = (TableDepth + sct_pkg::GroupSize - 1) / sct_pkg::GroupSize;
  localparam int unsigned PadN   = NumGrp * sct_pkg::GroupSize;

  // handshake and pipeline control
  logic in_acc, out_free, s1_adv;
  logic s1_valid_q, out_valid_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // fill count
  logic [CntW-1:0] count_q, count_d;
  logic            full, do_ins, refused, is_lookup;

  assign is_lookup = (sct_pkg::sct_func_e'(func_i) == sct_pkg::FuncLookup);
  assign full      = (count_q == CntW'(TableDepth));
  assign do_ins    = in_acc && !is_lookup && !full;
  assign refused   = !is_lookup && full;
  assign count_d   = do_ins ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // row of cells
  logic [RefBits-1:0] new_ref;
  sct_pkg::sct_nbr_t  nbr      [TableDepth];
  logic [RefBits-1:0] cell_ref [TableDepth];
  logic [PadN-1:0]    match_pad;
  logic [RefBits-1:0] ref_pad  [PadN];

  assign new_ref = RefBits'(ref_in_i);

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    sct_pkg::sct_nbr_t  prev;
    logic [RefBits-1:0] prev_ref;
    logic               occ;
    logic               match;

    if (i == 0) begin : g_first
      assign prev     = '0;
      assign prev_ref = '0;
    end else begin : g_next
      assign prev     = nbr[i-1];
      assign prev_ref = cell_ref[i-1];
    end

    assign occ = (CntW'(i) < count_q);

    sct_cell #(
      .RefBits(RefBits)
    ) u_cell (
      .clk_i     (clk_i),
      .ins_i     (do_ins),
      .key_i     (key_i),
      .ref_i     (new_ref),
      .term_i    (terminal_in_i),
      .occ_i     (occ),
      .prev_i    (prev),
      .prev_ref_i(prev_ref),
      .nbr_o     (nbr[i]),
      .ref_o     (cell_ref[i]),
      .match_o   (match)
    );

    assign match_pad[i] = match;
    assign ref_pad[i]   = cell_ref[i];
  end

  // padding past the last cell never matches
  for (genvar i = TableDepth; i < PadN; i++) begin : g_pad
    assign match_pad[i] = 1'b0;
    assign ref_pad[i]   = '0;
  end

  // first select level, registered
  logic [NumGrp-1:0]  grp_hit;
  logic [RefBits-1:0] grp_ref [NumGrp];

  for (genvar g = 0; g < NumGrp; g++) begin : g_grp
    logic [RefBits-1:0] refs [sct_pkg::GroupSize];
    for (genvar j = 0; j < sct_pkg::GroupSize; j++) begin : g_map
      assign refs[j] = ref_pad[g*sct_pkg::GroupSize + j];
    end

    sct_group #(
      .RefBits(RefBits)
    ) u_group (
      .clk_i  (clk_i),
      .load_i (in_acc),
      .match_i(match_pad[g*sct_pkg::GroupSize +: sct_pkg::GroupSize]),
      .ref_i  (refs),
      .hit_o  (grp_hit[g]),
      .ref_o  (grp_ref[g])
    );
  end

  // select stage side information
  logic            s1_lookup_q;
  logic            s1_status_q;
  logic [CntW-1:0] s1_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_lookup_q <= is_lookup;
      s1_status_q <= refused;
      s1_count_q  <= count_d;
    end
  end

  // second select level over the groups
  logic               sel_hit;
  logic [RefBits-1:0] sel_ref;

  always_comb begin
    sel_hit = 1'b0;
    sel_ref = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        sel_hit = 1'b1;
        sel_ref = grp_ref[g];
      end
    end
    if (!s1_lookup_q) begin
      sel_hit = 1'b0;
      sel_ref = '0;
    end
  end

  // output register
  logic                            found_q;
  logic [sct_pkg::RefFieldW-1:0]   ref_out_q;
  logic                            status_q;
  logic [sct_pkg::EntryCountW-1:0] count_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      found_q     <= sel_hit;
      ref_out_q   <= sct_pkg::RefFieldW'(sel_ref);
      status_q    <= s1_status_q;
      count_out_q <= sct_pkg::EntryCountW'(s1_count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign ref_out_o     = ref_out_q;
  assign status_o      = status_q;
  assign entry_count_o = count_out_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("fill count beyond table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the table by one");

  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sct_pkg::sct_status_e'(status_o) == sct_pkg::StatusFull) |-> !found_o)
    else $error("refused insert reports a match");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q)
    else $error("select stage dropped a request");

endmodule
